FILE: hw/rtl/ascii_frame_field_parser_defines.svh
// Assertion macros shared by the frame field parser modules
`ifndef ASCII_FRAME_FIELD_PARSER_DEFINES_SVH
`define ASCII_FRAME_FIELD_PARSER_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define AFFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define AFFP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define AFFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/affp_pkg.sv
// Shared types and constants of the frame field parser
package affp_pkg;

  localparam int unsigned NUM_FIELDS_DEF    = 3;
  localparam int unsigned MAX_FRAME_LEN_DEF = 64;
  localparam int unsigned FIELD_CHARS_DEF   = 16;

  localparam int unsigned NUM_SLOTS = 3;
  localparam int unsigned SLOT_W    = 2;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ACCUM_W   = 40;
  localparam int unsigned FDIG_W    = 3;

  localparam logic [FDIG_W-1:0]  FRAC_MAX  = 3'd5;
  localparam logic [ACCUM_W-1:0] ACCUM_CAP = 40'd1000000000000;

  localparam logic [BYTE_W-1:0] CHR_NUL         = 8'h00;
  localparam logic [BYTE_W-1:0] CHR_FRAME_OPEN  = 8'h26;
  localparam logic [BYTE_W-1:0] CHR_FRAME_CLOSE = 8'h2A;
  localparam logic [BYTE_W-1:0] CHR_FIELD_END   = 8'h3B;
  localparam logic [BYTE_W-1:0] CHR_PLUS        = 8'h2B;
  localparam logic [BYTE_W-1:0] CHR_MINUS       = 8'h2D;
  localparam logic [BYTE_W-1:0] CHR_POINT       = 8'h2E;
  localparam logic [BYTE_W-1:0] CHR_ZERO        = 8'h30;
  localparam logic [BYTE_W-1:0] CHR_NINE        = 8'h39;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef enum logic {
    OP_STAGE  = 1'b0,
    OP_COMMIT = 1'b1
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e               op;
    logic [SLOT_W-1:0]     slot;
    logic                  neg;
    logic [FDIG_W-1:0]     fdig;
    logic [ACCUM_W-1:0]    accum;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

endpackage

FILE: hw/rtl/affp_if.sv
// Handshake channels of the frame field parser: received bytes and frame results
interface affp_rx_if import affp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface affp_res_if import affp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_first;
  logic signed [VALUE_W-1:0] value_second;
  logic signed [VALUE_W-1:0] value_third;
  logic [SLOT_W-1:0]         fields_updated;

  modport source (output valid, output value_first, output value_second,
                  output value_third, output fields_updated, input ready);
  modport sink   (input valid, input value_first, input value_second,
                  input value_third, input fields_updated, output ready);
endinterface

FILE: hw/rtl/affp_front.sv
// Byte classifier: frame tracking and per-field digit accumulation
`include "ascii_frame_field_parser_defines.svh"

module affp_front import affp_pkg::*; #(
  parameter int unsigned NUM_FIELDS    = NUM_FIELDS_DEF,
  parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
  parameter int unsigned FIELD_CHARS   = FIELD_CHARS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  affp_rx_if.sink    rx_i,
  input  logic       q_full_i,
  output cmd_beat_t  q_push_o
);

  localparam int unsigned LEN_W = $clog2(MAX_FRAME_LEN + 1);
  localparam int unsigned CHR_W = $clog2(FIELD_CHARS);

  logic               in_frame_q, in_frame_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [CHR_W-1:0]   fchars_q, fchars_d;
  logic [ACCUM_W-1:0] accum_q, accum_d;
  logic               neg_q, neg_d;
  logic               frac_q, frac_d;
  logic [FDIG_W-1:0]  fdig_q, fdig_d;
  logic               done_q, done_d;

  logic               accept;
  logic [BYTE_W-1:0]  c;
  logic               is_digit;
  logic [ACCUM_W+3:0] acc_ten;
  logic [ACCUM_W-1:0] acc_next;

  assign rx_i.ready = !q_full_i;
  assign accept     = rx_i.valid && rx_i.ready;
  assign c          = rx_i.rx_byte;
  assign is_digit   = (c >= CHR_ZERO) && (c <= CHR_NINE);

  // accum * 10 + digit, clamped at the cap
  assign acc_ten  = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0}
                  + {{ACCUM_W{1'b0}}, c[3:0]};
  assign acc_next = (acc_ten > {4'b0000, ACCUM_CAP}) ? ACCUM_CAP : acc_ten[ACCUM_W-1:0];

  always_comb begin
    logic do_clear;
    do_clear   = 1'b0;
    in_frame_d = in_frame_q;
    len_d      = len_q;
    slot_d     = slot_q;
    fchars_d   = fchars_q;
    accum_d    = accum_q;
    neg_d      = neg_q;
    frac_d     = frac_q;
    fdig_d     = fdig_q;
    done_d     = done_q;

    q_push_o.valid     = 1'b0;
    q_push_o.cmd.op    = OP_STAGE;
    q_push_o.cmd.slot  = slot_q;
    q_push_o.cmd.neg   = neg_q;
    q_push_o.cmd.fdig  = fdig_q;
    q_push_o.cmd.accum = accum_q;

    if (accept) begin
      if (c == CHR_FRAME_OPEN) begin
        in_frame_d = 1'b1;
        len_d      = '0;
        slot_d     = '0;
        do_clear   = 1'b1;
      end else if (c == CHR_FRAME_CLOSE) begin
        in_frame_d = 1'b0;
        len_d      = '0;
        if (in_frame_q) begin
          q_push_o.valid  = 1'b1;
          q_push_o.cmd.op = OP_COMMIT;
          slot_d          = '0;
          do_clear        = 1'b1;
        end
      end else if (in_frame_q && (len_q < LEN_W'(MAX_FRAME_LEN))) begin
        len_d = len_q + LEN_W'(1);
        if (c == CHR_NUL) begin
          // stop parsing the rest of the frame
          len_d = LEN_W'(MAX_FRAME_LEN);
        end else if (c == CHR_FIELD_END) begin
          if (slot_q < SLOT_W'(NUM_FIELDS)) begin
            q_push_o.valid = 1'b1;
            slot_d         = slot_q + SLOT_W'(1);
          end
          do_clear = 1'b1;
        end else if (fchars_q < CHR_W'(FIELD_CHARS - 1)) begin
          fchars_d = fchars_q + CHR_W'(1);
          if (!done_q) begin
            if ((fchars_q == '0) && ((c == CHR_PLUS) || (c == CHR_MINUS))) begin
              neg_d = (c == CHR_MINUS);
            end else if (is_digit) begin
              if (!frac_q) begin
                accum_d = acc_next;
              end else if (fdig_q < FRAC_MAX) begin
                fdig_d  = fdig_q + FDIG_W'(1);
                accum_d = acc_next;
              end
            end else if ((c == CHR_POINT) && !frac_q) begin
              frac_d = 1'b1;
            end else begin
              done_d = 1'b1;
            end
          end
        end
      end

      if (do_clear) begin
        fchars_d = '0;
        accum_d  = '0;
        neg_d    = 1'b0;
        frac_d   = 1'b0;
        fdig_d   = '0;
        done_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      len_q      <= '0;
      slot_q     <= '0;
      fchars_q   <= '0;
      accum_q    <= '0;
      neg_q      <= 1'b0;
      frac_q     <= 1'b0;
      fdig_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      len_q      <= len_d;
      slot_q     <= slot_d;
      fchars_q   <= fchars_d;
      accum_q    <= accum_d;
      neg_q      <= neg_d;
      frac_q     <= frac_d;
      fdig_q     <= fdig_d;
      done_q     <= done_d;
    end
  end

  `AFFP_ASSERT(a_slot_bound, slot_q <= SLOT_W'(NUM_FIELDS), "slot index beyond field count")
  `AFFP_ASSERT_IMPL(a_len_idle, !in_frame_q, len_q == '0, "frame length kept outside a frame")

endmodule

FILE: hw/rtl/affp_cmd_fifo.sv
// Short command queue between the byte classifier and the conversion pipeline
`include "ascii_frame_field_parser_defines.svh"

module affp_cmd_fifo import affp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_beat_t push_i,
  output logic      full_o,
  output cmd_beat_t head_o,
  input  logic      pop_i
);

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  push, pop;

  assign full_o       = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign push         = push_i.valid && !full_o;
  assign pop          = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  `AFFP_ASSERT(a_no_overflow, !(push_i.valid && full_o), "command pushed into a full queue")
  `AFFP_ASSERT(a_cnt_bound, cnt_q <= FIFO_CNT_W'(FIFO_DEPTH), "queue count beyond depth")

endmodule

FILE: hw/rtl/affp_back.sv
// Conversion pipeline to Q16.16, slot staging, commit and result register
`include "ascii_frame_field_parser_defines.svh"

module affp_back import affp_pkg::*; #(
  parameter int unsigned NUM_FIELDS = NUM_FIELDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_beat_t   head_i,
  output logic        pop_o,
  affp_res_if.source  res_o
);

  localparam int unsigned SCALED_W   = 32;
  localparam int unsigned POW_W      = 17;
  localparam int unsigned PROD_W     = SCALED_W + POW_W;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned REM_W      = 12;
  localparam int unsigned T_W        = REM_W + DIGIT_W;
  localparam int unsigned ROUND_W    = 11;
  localparam int unsigned DIV_IN_W   = 1 + SCALED_W + ROUND_W;
  localparam int unsigned DIV_STAGES = DIV_IN_W / DIGIT_W;
  localparam int unsigned QUOT_W     = 32;
  localparam int         DIVISOR    = 3125;

  // round(scaled * 65536 / 100000) == floor((scaled * 2^11 + 1562) / 3125)
  localparam logic [ROUND_W-1:0] ROUND_LOW = 11'd1562;
  localparam logic [PROD_W-1:0]  SAT_LIMIT = 49'd3276800000;

  typedef struct packed {
    logic                vld;
    cmd_op_e             op;
    logic [SLOT_W-1:0]   slot;
    logic                neg;
    logic                sat;
    logic [SCALED_W-1:0] scaled;
    logic [REM_W-1:0]    rem;
    logic [QUOT_W-1:0]   quot;
  } div_stage_t;

  function automatic logic [POW_W-1:0] pow10_f(input logic [FDIG_W-1:0] fd);
    logic [POW_W-1:0] p;
    case (fd)
      3'd0:    p = 17'd100000;
      3'd1:    p = 17'd10000;
      3'd2:    p = 17'd1000;
      3'd3:    p = 17'd100;
      3'd4:    p = 17'd10;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

  // one radix-16 step of long division by the constant divisor
  function automatic div_stage_t div_step_f(input div_stage_t src,
                                            input logic [DIGIT_W-1:0] nib);
    div_stage_t         r;
    logic [T_W-1:0]     t;
    logic [DIGIT_W-1:0] q;
    r = src;
    t = {src.rem, nib};
    q = '0;
    for (int j = 1; j < (1 << DIGIT_W); j++) begin
      if (t >= T_W'(j * DIVISOR)) begin
        q = DIGIT_W'(j);
      end
    end
    r.rem  = REM_W'(t - T_W'(int'(q) * DIVISOR));
    r.quot = {src.quot[QUOT_W-DIGIT_W-1:0], q};
    return r;
  endfunction

  logic adv;

  logic              m_vld_q;
  cmd_op_e           m_op_q;
  logic [SLOT_W-1:0] m_slot_q;
  logic              m_neg_q;
  logic              m_hi_q;
  logic [PROD_W-1:0] m_prod_q;
  logic [PROD_W-1:0] prod;

  div_stage_t div_in;
  div_stage_t div_d [DIV_STAGES];
  div_stage_t div_q [DIV_STAGES];
  div_stage_t fin;

  logic [VALUE_W-1:0] fin_value;
  logic               do_stage, do_commit;
  logic [VALUE_W-1:0] commit_val [NUM_SLOTS];

  logic              res_vld_q;
  logic [SLOT_W-1:0] upd_q;

  // advance the whole pipeline unless a finished result is still waiting
  assign adv   = !res_vld_q || res_o.ready;
  assign pop_o = adv;

  assign prod = {{POW_W{1'b0}}, head_i.cmd.accum[SCALED_W-1:0]}
              * {{SCALED_W{1'b0}}, pow10_f(head_i.cmd.fdig)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= head_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_op_q   <= head_i.cmd.op;
      m_slot_q <= head_i.cmd.slot;
      m_neg_q  <= head_i.cmd.neg;
      m_hi_q   <= |head_i.cmd.accum[ACCUM_W-1:SCALED_W];
      m_prod_q <= prod;
    end
  end

  always_comb begin
    div_in.vld    = m_vld_q;
    div_in.op     = m_op_q;
    div_in.slot   = m_slot_q;
    div_in.neg    = m_neg_q;
    div_in.sat    = m_hi_q || (m_prod_q >= SAT_LIMIT);
    div_in.scaled = m_prod_q[SCALED_W-1:0];
    div_in.rem    = '0;
    div_in.quot   = '0;
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    div_stage_t          src;
    logic [DIV_IN_W-1:0] dividend;
    if (s == 0) begin : g_first
      assign src = div_in;
    end else begin : g_next
      assign src = div_q[s-1];
    end
    assign dividend = {1'b0, src.scaled, ROUND_LOW};
    assign div_d[s] = div_step_f(src, dividend[DIV_IN_W-1-DIGIT_W*s -: DIGIT_W]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        div_q[i] <= '0;
      end
    end else if (adv) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        div_q[i] <= div_d[i];
      end
    end
  end

  assign fin = div_q[DIV_STAGES-1];

  always_comb begin
    if (fin.sat) begin
      fin_value = fin.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (fin.neg) begin
      fin_value = VALUE_W'(0) - fin.quot;
    end else begin
      fin_value = fin.quot;
    end
  end

  assign do_stage  = adv && fin.vld && (fin.op == OP_STAGE);
  assign do_commit = adv && fin.vld && (fin.op == OP_COMMIT);

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
    if (k < NUM_FIELDS) begin : g_live
      logic [VALUE_W-1:0] stage_q;
      logic [VALUE_W-1:0] commit_q;

      always_ff @(posedge clk_i) begin
        if (do_stage && (fin.slot == SLOT_W'(k))) begin
          stage_q <= fin_value;
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          commit_q <= '0;
        end else if (do_commit && (fin.slot > SLOT_W'(k))) begin
          commit_q <= stage_q;
        end
      end

      assign commit_val[k] = commit_q;
    end else begin : g_idle
      assign commit_val[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= fin.vld && (fin.op == OP_COMMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_commit) begin
      upd_q <= fin.slot;
    end
  end

  // committed slots only change on the next commit, so they serve as the payload
  assign res_o.valid          = res_vld_q;
  assign res_o.value_first    = $signed(commit_val[0]);
  assign res_o.value_second   = $signed(commit_val[1]);
  assign res_o.value_third    = $signed(commit_val[2]);
  assign res_o.fields_updated = upd_q;

  `AFFP_ASSERT_IMPL(a_commit_count, fin.vld && (fin.op == OP_COMMIT), fin.slot <= SLOT_W'(NUM_FIELDS), "commit count beyond field count")
  `AFFP_ASSERT_NEXT(a_hold_slots, res_vld_q && !res_o.ready, $stable(commit_val[0]) && $stable(commit_val[1]) && $stable(commit_val[2]), "committed slots changed under a waiting result")

endmodule

FILE: hw/rtl/ascii_frame_field_parser.sv
// Top level of the ASCII frame field parser.
// Throughput: one received byte per cycle; ready drops only when the 4-entry command queue
// fills while a finished result waits to be taken.
// Result path: a frame's closing '*' passes through the command queue, the multiply stage and
// the eleven radix-16 stages of the divide-by-constant pipeline into the result register.
// Reset: asynchronous, clears frame state, queue and pipeline; committed values read zero.
module ascii_frame_field_parser import affp_pkg::*; #(
  parameter int unsigned NUM_FIELDS    = NUM_FIELDS_DEF,
  parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
  parameter int unsigned FIELD_CHARS   = FIELD_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  affp_rx_if.sink     rx_i,
  affp_res_if.source  res_o
);

  cmd_beat_t q_push;
  cmd_beat_t q_head;
  logic      q_full;
  logic      q_pop;

  affp_front #(
    .NUM_FIELDS    (NUM_FIELDS),
    .MAX_FRAME_LEN (MAX_FRAME_LEN),
    .FIELD_CHARS   (FIELD_CHARS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_i     (rx_i),
    .q_full_i (q_full),
    .q_push_o (q_push)
  );

  affp_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .full_o (q_full),
    .head_o (q_head),
    .pop_i  (q_pop)
  );

  affp_back #(
    .NUM_FIELDS (NUM_FIELDS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (q_head),
    .pop_o  (q_pop),
    .res_o  (res_o)
  );

endmodule

FILE: dv/tb_ascii_frame_field_parser.sv
// Self-checking testbench of the ASCII frame field parser: byte stream in, frame results out
`timescale 1ns / 1ps

module tb_ascii_frame_field_parser import affp_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_BYTES = 1550;
  localparam logic [63:0] Q16_SAT_SCALED = 64'd3276800000;

  typedef struct {
    logic signed [VALUE_W-1:0] value_first;
    logic signed [VALUE_W-1:0] value_second;
    logic signed [VALUE_W-1:0] value_third;
    logic [SLOT_W-1:0]         fields_updated;
  } frame_result_t;

  bit clk_i = 1'b0;
  bit rst_ni;

  affp_rx_if  rx ();
  affp_res_if res ();

  ascii_frame_field_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx),
    .res_o  (res)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bytes waiting to be sent and frame results waiting to arrive
  logic [BYTE_W-1:0] byte_q[$];
  frame_result_t     frame_results_q[$];

  int unsigned mismatches, bytes_taken, results_seen, full_frames, bytes_queued, cycles;
  bit          rx_took, calm, hold_req, hold_started;
  int unsigned hold_left;

  // Parser state as the block keeps it
  bit                 in_frame;
  logic [6:0]         frame_len;
  logic [SLOT_W-1:0]  slot_idx;
  logic [4:0]         field_len;
  logic [47:0]        digit_accum;
  bit                 is_negative, in_fraction, number_over;
  logic [FDIG_W-1:0]  frac_digits;
  logic [VALUE_W-1:0] staged[NUM_SLOTS];
  logic [VALUE_W-1:0] committed[NUM_SLOTS];

  task note_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [VALUE_W-1:0] field_to_q16(logic [47:0] acc, logic [FDIG_W-1:0] fd,
                                                     bit neg);
    logic [63:0] scale, scaled, mag;
    scale = 64'd1;
    for (int i = fd; i < 5; i++) scale = scale * 64'd10;
    scaled = acc * scale;
    if (scaled >= Q16_SAT_SCALED) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag = (scaled * 64'd65536 + 64'd50000) / 64'd100000;
    if (!neg) return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    if (mag > 64'h8000_0000) mag = 64'h8000_0000;
    return -mag[31:0];
  endfunction

  task clear_field();
    field_len   = '0;
    digit_accum = '0;
    is_negative = 1'b0;
    in_fraction = 1'b0;
    frac_digits = '0;
    number_over = 1'b0;
  endtask

  task take_char(input logic [BYTE_W-1:0] c);
    bit first;
    if (field_len < FIELD_CHARS_DEF - 1) begin
      first = (field_len == 0);
      field_len++;
      if (!number_over) begin
        if (first && (c == CHR_PLUS || c == CHR_MINUS)) begin
          is_negative = (c == CHR_MINUS);
        end else if (c >= CHR_ZERO && c <= CHR_NINE) begin
          // fraction digits past the fifth are dropped
          if (!(in_fraction && frac_digits >= FRAC_MAX)) begin
            if (in_fraction) frac_digits++;
            digit_accum = digit_accum * 48'd10 + 48'(c - CHR_ZERO);
            if (digit_accum > 48'(ACCUM_CAP)) digit_accum = 48'(ACCUM_CAP);
          end
        end else if (c == CHR_POINT && !in_fraction) begin
          in_fraction = 1'b1;
        end else begin
          number_over = 1'b1;
        end
      end
    end
  endtask

  task predict_byte(input logic [BYTE_W-1:0] c);
    frame_result_t r;
    if (c == CHR_FRAME_OPEN) begin
      in_frame  = 1'b1;
      frame_len = '0;
      slot_idx  = '0;
      clear_field();
    end else if (c == CHR_FRAME_CLOSE) begin
      if (in_frame) begin
        for (int k = 0; k < NUM_SLOTS; k++)
          if (k < slot_idx) committed[k] = staged[k];
        r.value_first    = committed[0];
        r.value_second   = committed[1];
        r.value_third    = committed[2];
        r.fields_updated = slot_idx;
        frame_results_q.push_back(r);
        slot_idx = '0;
        clear_field();
      end
      in_frame  = 1'b0;
      frame_len = '0;
    end else if (in_frame && frame_len < MAX_FRAME_LEN_DEF) begin
      frame_len++;
      if (c == CHR_NUL) begin
        frame_len = MAX_FRAME_LEN_DEF;
      end else if (c == CHR_FIELD_END) begin
        if (slot_idx < NUM_FIELDS_DEF) begin
          staged[slot_idx] = field_to_q16(digit_accum, frac_digits, is_negative);
          slot_idx++;
        end
        clear_field();
      end else begin
        take_char(c);
      end
    end
  endtask

  // Stimulus helpers
  task push_byte(input logic [BYTE_W-1:0] b);
    byte_q.push_back(b);
    bytes_queued++;
  endtask

  task push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s.getc(i));
  endtask

  function automatic logic [BYTE_W-1:0] loose_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(255));
    while (b == CHR_FRAME_OPEN || b == CHR_FRAME_CLOSE || b == CHR_FIELD_END);
    return b;
  endfunction

  task push_digits(input int unsigned n);
    repeat (n) push_byte(CHR_ZERO + BYTE_W'($urandom_range(9)));
  endtask

  task gen_number();
    int unsigned sign_pick;
    sign_pick = $urandom_range(2);
    if (sign_pick == 1) push_byte(CHR_PLUS);
    else if (sign_pick == 2) push_byte(CHR_MINUS);
    if ($urandom_range(19) == 0) begin
      // land right on the saturation edge
      if ($urandom_range(1)) push_text("32767.99999");
      else push_text("32768");
    end else begin
      push_digits(($urandom_range(9) == 0) ? $urandom_range(4, 14) : $urandom_range(3));
      if ($urandom_range(1)) begin
        push_byte(CHR_POINT);
        push_digits($urandom_range(7));
      end
    end
    if ($urandom_range(9) == 0) begin
      push_byte($urandom_range(1) ? CHR_POINT : loose_byte());
      push_digits($urandom_range(2));
    end
  endtask

  task gen_field();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick == 0) repeat ($urandom_range(1, 6)) push_byte(loose_byte());
    else if (pick == 1) push_digits($urandom_range(16, 24));
    else gen_number();
  endtask

  task gen_frame();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      push_byte(CHR_FRAME_OPEN);
      repeat ($urandom_range(4)) begin
        gen_field();
        push_byte(CHR_FIELD_END);
      end
      if ($urandom_range(9) < 3) gen_field();
      push_byte(CHR_FRAME_CLOSE);
    end else if (pick < 80) begin
      push_byte(CHR_FRAME_OPEN);
      repeat ($urandom_range(60, 80))
        if ($urandom_range(4) == 0) push_byte(CHR_FIELD_END);
        else push_digits(1);
      push_byte(CHR_FRAME_CLOSE);
    end else if (pick < 85) begin
      push_byte(CHR_FRAME_OPEN);
      gen_field();
      push_byte(CHR_FIELD_END);
      push_byte(CHR_NUL);
      gen_field();
      push_byte(CHR_FIELD_END);
      push_byte(CHR_FRAME_CLOSE);
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 6)) push_byte(BYTE_W'($urandom_range(255)));
      if ($urandom_range(1)) push_byte(CHR_FRAME_CLOSE);
    end else if (pick < 97) begin
      // reopen a frame half way through
      push_byte(CHR_FRAME_OPEN);
      gen_field();
      push_byte(CHR_FIELD_END);
      push_byte(CHR_FRAME_OPEN);
      gen_field();
      push_byte(CHR_FIELD_END);
      push_byte(CHR_FRAME_CLOSE);
    end else begin
      push_byte(CHR_FRAME_CLOSE);
    end
  endtask

  // Sender: hold the item until it is taken, idle at random
  always @(negedge clk_i) begin
    if (rst_ni && !(rx.valid && !rx_took)) begin
      if (byte_q.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
        rx.valid   <= 1'b1;
        rx.rx_byte <= byte_q[0];
      end else begin
        rx.valid   <= 1'b0;
        rx.rx_byte <= BYTE_W'($urandom_range(255));
      end
    end
  end

  // Receiver: stall at random, and for one long stretch
  always @(negedge clk_i) begin
    if (rst_ni) res.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 19);
  end

  always @(posedge clk_i) begin
    if (hold_req && !hold_started) begin
      hold_started <= 1'b1;
      hold_left    <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check results in order, advance the predictor on each accepted byte
  always @(posedge clk_i) begin : monitor
    frame_result_t want;
    rx_took = rst_ni && rx.valid && rx.ready;
    if (rst_ni && res.valid && res.ready) begin
      if (frame_results_q.size() == 0) begin
        note_mismatch("result with no frame closed", res.fields_updated, 0);
      end else begin
        want = frame_results_q.pop_front();
        if (res.value_first !== want.value_first)
          note_mismatch("value_first", res.value_first, want.value_first);
        if (res.value_second !== want.value_second)
          note_mismatch("value_second", res.value_second, want.value_second);
        if (res.value_third !== want.value_third)
          note_mismatch("value_third", res.value_third, want.value_third);
        if (res.fields_updated !== want.fields_updated)
          note_mismatch("fields_updated", res.fields_updated, want.fields_updated);
        if (want.fields_updated == 2'd3) full_frames++;
      end
      results_seen++;
    end
    if (rx_took) begin
      predict_byte(rx.rx_byte);
      void'(byte_q.pop_front());
      bytes_taken++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned base;
    rst_ni     = 1'b0;
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    res.ready  = 1'b0;
    in_frame   = 1'b0;
    frame_len  = '0;
    slot_idx   = '0;
    clear_field();
    for (int k = 0; k < NUM_SLOTS; k++) begin
      staged[k]    = '0;
      committed[k] = '0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: stray close, sign and saturation edges, empty fields, bad syntax,
    // extra and unterminated fields, NUL, frame with no fields, reopened frame
    push_text("*x;");
    push_text("&-32768;32767.99999;+.5;*");
    push_text("&;1.2.3;-9;7;4*");
    push_text("&12a3;");
    push_byte(CHR_NUL);
    push_text("5;*&8*&1;&0.000009;*");
    push_byte(8'hFF);
    while (byte_q.size() != 0 || frame_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    bytes_queued = 0;
    while (bytes_queued < RANDOM_BYTES) gen_frame();
    hold_req = 1'b1;
    base = bytes_taken;
    while (bytes_taken < base + 700) @(posedge clk_i);
    calm = 1'b1;
    while (bytes_taken < base + 1000 && byte_q.size() != 0) @(posedge clk_i);
    calm = 1'b0;

    while (byte_q.size() != 0 || frame_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    for (int i = 0; i < frame_results_q.size(); i++)
      note_mismatch("frame result never arrived", 0, frame_results_q[i].fields_updated);

    $display("Sent %0d bytes; checked %0d frame results, %0d of them with all slots updated",
             bytes_taken, results_seen, full_frames);
    $display("Included a %0d-cycle receiver stall and a stretch with no idling", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/affp_pkg.sv
hw/rtl/affp_if.sv
hw/rtl/affp_front.sv
hw/rtl/affp_cmd_fifo.sv
hw/rtl/affp_back.sv
hw/rtl/ascii_frame_field_parser.sv
dv/tb_ascii_frame_field_parser.sv
